@@ rtl/smlp_pkg.sv @@
// ----------------------------------------------------------------------------
// smlp_pkg
// Shared types and constants for the stereo mixer with one-pole low-pass.
// ----------------------------------------------------------------------------
package smlp_pkg;

   localparam int ONE_FIXED = 65536;
   localparam int PCT_SCALE = 100;
   localparam int PCT_RANGE = 128;

   localparam logic [15:0] PSG_OFFSET = 16'h4000;

   typedef enum logic [1:0] {
      MIX_OFF  = 2'd0,
      MIX_FM   = 2'd1,
      MIX_PSG  = 2'd2,
      MIX_BOTH = 2'd3
   } mix_mode_type;

   typedef enum logic [1:0] {
      CSR_FM_ENABLE      = 2'd0,
      CSR_PSG_ENABLE     = 2'd1,
      CSR_FILTER_PERCENT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic load_prod;
      logic load_acc;
   } pole_ctrl_type;

   typedef logic [16:0] coeff_table_type [PCT_RANGE];

   function automatic coeff_table_type build_coeff_table();
      coeff_table_type t;
      for (int i = 0; i < PCT_RANGE; i++) begin
         t[i] = 17'((ONE_FIXED * i) / PCT_SCALE);
      end
      return t;
   endfunction

   localparam coeff_table_type CoeffTable = build_coeff_table();

   localparam logic [6:0]         PCT_RESET     = 7'd50;
   localparam logic [16:0]        COEF_A_RESET  = 17'd32768;
   localparam logic signed [17:0] COEF_B_RESET  = 18'sd32768;
   localparam logic signed [17:0] ONE_FIXED_S18 = 18'sd65536;

endpackage

@@ rtl/stereo_mix_one_pole_lowpass_top.sv @@
// ----------------------------------------------------------------------------
// stereo_mix_one_pole_lowpass_top
// Stereo FM/PSG mixer with a one-pole low-pass filter on each channel.
//
// Input words arrive on req_ (FM left/right, PSG word, block end on tlast);
// filtered stereo words leave on rsp_ with the block end copied to tlast.
// csr_ writes the FM enable, PSG enable and filter percent; write them only
// while no word is in flight.
// A word accepted on req_ goes through stage 1, product and result registers.
// Throughput: one word per cycle unless rsp_ stalls; the accumulator update
// sets it: one 16x18 multiply and a 32-bit add from acc register to acc register.
// The input product x*b sits in the stage before, off that loop.
// When rsp_tready is low a full result register holds; the two earlier stages
// keep taking words until they are full, then req_tready falls.
// Reset empties the pipeline, clears both accumulators and restores the
// registers to FM and PSG enabled with a percent of fifty.
// ----------------------------------------------------------------------------
module stereo_mix_one_pole_lowpass_top import smlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // fm_left, fm_right, psg_raw
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_left, out_right
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   logic               fm_enable_ff;
   logic               psg_enable_ff;
   logic [16:0]        coef_a_ff;
   logic signed [17:0] coef_b_ff;
   logic [16:0]        coef_a_in;

   logic               v1_ff;
   logic [47:0]        data1_ff;
   logic               last1_ff;
   mix_mode_type       mode1_ff;

   logic               v2_ff;
   logic               last2_ff;
   logic               active2_ff;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_last_ff;

   logic               en1;
   logic               en2;
   logic               en3;
   mix_mode_type       mode_in;
   logic signed [17:0] x_left;
   logic signed [17:0] x_right;
   pole_ctrl_type      pole_ctrl;
   logic [15:0]        left_hi;
   logic [15:0]        right_hi;

   always_comb begin
      en3        = !rsp_valid_ff || rsp_tready;
      en2        = !v2_ff || en3;
      en1        = !v1_ff || en2;
      req_tready = en1;
      mode_in    = mix_mode_type'({psg_enable_ff, fm_enable_ff});
      coef_a_in  = CoeffTable[csr_wdata];
      pole_ctrl.load_prod = v1_ff && en2;
      pole_ctrl.load_acc  = v2_ff && en3 && active2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fm_enable_ff  <= 1'b1;
         psg_enable_ff <= 1'b1;
         coef_a_ff     <= COEF_A_RESET;
         coef_b_ff     <= COEF_B_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FM_ENABLE:  fm_enable_ff  <= csr_wdata[0];
            CSR_PSG_ENABLE: psg_enable_ff <= csr_wdata[0];
            CSR_FILTER_PERCENT: begin
               coef_a_ff <= coef_a_in;
               coef_b_ff <= ONE_FIXED_S18 - $signed({1'b0, coef_a_in});
            end
            default: ;
         endcase
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (en1 && req_tvalid) begin
         data1_ff <= req_tdata;
         last1_ff <= req_tlast;
         mode1_ff <= mode_in;
      end
      if (en2 && v1_ff) begin
         last2_ff   <= last1_ff;
         active2_ff <= (mode1_ff != MIX_OFF);
      end
      if (en3 && v2_ff) begin
         rsp_data_ff <= active2_ff ? {right_hi, left_hi} : '0;
         rsp_last_ff <= last2_ff;
      end
   end

   smlp_mix u_mix (
      .mode     (mode1_ff),
      .fm_left  ($signed(data1_ff[15:0])),
      .fm_right ($signed(data1_ff[31:16])),
      .psg_raw  (data1_ff[47:32]),
      .x_left   (x_left),
      .x_right  (x_right)
   );

   smlp_pole u_pole_left (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (pole_ctrl),
      .x           (x_left),
      .coef_a      (coef_a_ff),
      .coef_b      (coef_b_ff),
      .acc_next_hi (left_hi)
   );

   smlp_pole u_pole_right (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (pole_ctrl),
      .x           (x_right),
      .coef_a      (coef_a_ff),
      .coef_b      (coef_b_ff),
      .acc_next_hi (right_hi)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/smlp_mix.sv @@
// ----------------------------------------------------------------------------
// smlp_mix
// Source mixer: forms the filter input of each channel from FM and PSG.
// ----------------------------------------------------------------------------
module smlp_mix import smlp_pkg::*; (
   input  mix_mode_type       mode,
   input  logic signed [15:0] fm_left,
   input  logic signed [15:0] fm_right,
   input  logic [15:0]        psg_raw,
   output logic signed [17:0] x_left,
   output logic signed [17:0] x_right
);

   logic signed [17:0] fm_left_x3;
   logic signed [17:0] fm_right_x3;
   logic signed [15:0] fm_left_q;
   logic signed [15:0] fm_right_q;
   logic signed [16:0] psg_wide;
   logic signed [15:0] psg_both;
   logic [15:0]        psg_wrap;
   logic signed [15:0] psg_only;

   always_comb begin
      fm_left_x3  = ({{2{fm_left[15]}}, fm_left} <<< 1) + {{2{fm_left[15]}}, fm_left};
      fm_right_x3 = ({{2{fm_right[15]}}, fm_right} <<< 1) + {{2{fm_right[15]}}, fm_right};
      fm_left_q   = fm_left_x3[17:2];
      fm_right_q  = fm_right_x3[17:2];
      psg_wide    = $signed({psg_raw[15], psg_raw}) - $signed({1'b0, PSG_OFFSET});
      psg_both    = psg_wide[16:1];
      psg_wrap    = psg_raw - PSG_OFFSET;
      psg_only    = {psg_wrap[15], psg_wrap[15:1]};
   end

   always_comb begin
      unique case (mode)
         MIX_BOTH: begin
            x_left  = {{2{psg_both[15]}}, psg_both} + {{2{fm_left_q[15]}}, fm_left_q};
            x_right = {{2{psg_both[15]}}, psg_both} + {{2{fm_right_q[15]}}, fm_right_q};
         end
         MIX_FM: begin
            x_left  = {{2{fm_left_q[15]}}, fm_left_q};
            x_right = {{2{fm_right_q[15]}}, fm_right_q};
         end
         MIX_PSG: begin
            x_left  = {{2{psg_only[15]}}, psg_only};
            x_right = {{2{psg_only[15]}}, psg_only};
         end
         default: begin
            x_left  = '0;
            x_right = '0;
         end
      endcase
   end

endmodule

@@ rtl/smlp_pole.sv @@
// ----------------------------------------------------------------------------
// smlp_pole
// One-pole low-pass for one channel: input product stage and accumulator.
// ----------------------------------------------------------------------------
module smlp_pole import smlp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  pole_ctrl_type      ctrl,
   input  logic signed [17:0] x,
   input  logic [16:0]        coef_a,
   input  logic signed [17:0] coef_b,
   output logic [15:0]        acc_next_hi
);

   logic signed [35:0] prod_full;
   logic [31:0]        prod_ff;
   logic [31:0]        prod_in;
   logic signed [33:0] fb_full;
   logic [31:0]        acc_ff;
   logic [31:0]        acc_in;

   always_comb begin
      prod_full   = x * coef_b;
      prod_in     = prod_full[31:0];
      fb_full     = $signed(acc_ff[31:16]) * $signed({1'b0, coef_a});
      acc_in      = fb_full[31:0] + prod_ff;
      acc_next_hi = acc_in[31:16];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.load_acc) begin
         acc_ff <= acc_in;
      end
   end

endmodule
